@@ rtl/nnis_pkg.sv @@
// shared types and constants of the nearest-neighbor image scaler
package nnis_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int DIM_W       = 9;
    localparam int CRD_W       = 8;
    localparam int PIX_W       = 32;
    localparam int FRAME_W     = ADDR_W + 1;
    localparam int REG_ADDR_W  = 4;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        REG_SRC_WIDTH     = 2'd0,
        REG_SRC_HEIGHT    = 2'd1,
        REG_DST_WIDTH     = 2'd2,
        REG_CHANNEL_COUNT = 2'd3
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EMIT = 1'b1
    } t_op;

    // frame geometry, recomputed after every register write
    typedef struct packed {
        logic [DIM_W-1:0]   src_width;
        logic [DIM_W-1:0]   dst_width;
        logic [DIM_W-1:0]   dest_height;
        logic [FRAME_W-1:0] frame;
        logic [DIM_W-1:0]   wdiv;
        logic [CRD_W-1:0]   wmod;
        logic [CRD_W-1:0]   winit_q;
        logic [CRD_W-1:0]   winit_r;
        logic [DIM_W-1:0]   hdiv;
        logic [CRD_W-1:0]   hmod;
        logic [CRD_W-1:0]   hinit_q;
        logic [CRD_W-1:0]   hinit_r;
        logic               alpha_en;
    } t_geom;

    typedef struct packed {
        logic busy;
        logic restart;
    } t_setup_stat;

    typedef struct packed {
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
        logic [CRD_W-1:0]  col;
        logic [CRD_W-1:0]  row;
        logic              last;
    } t_qent;

endpackage

@@ rtl/nnis_setup.sv @@
// configuration registers and iterative divider that derives the frame geometry
module nnis_setup import nnis_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output t_geom                 o_geom,
    output t_setup_stat           o_stat
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_DH    = 6'b000010,
        ST_WDIV  = 6'b000100,
        ST_WINIT = 6'b001000,
        ST_HDIV  = 6'b010000,
        ST_HINIT = 6'b100000
    } t_state;

    localparam logic [4:0] LAST_STEP = 5'(FRAME_W - 1);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    t_state             r_state;
    logic               r_load;
    logic               r_done;
    logic [4:0]         r_cnt;
    logic [DIM_W-1:0]   r_rem;
    logic [FRAME_W-1:0] r_quo;
    logic [DIM_W-1:0]   r_divisor;
    logic [DIM_W-1:0]   r_sw;
    logic [DIM_W-1:0]   r_sh;
    logic [DIM_W-1:0]   r_dw;
    logic [2:0]         r_chan;
    t_geom              r_geom;

    logic                 wr;
    logic [DIM_W:0]       t;
    logic                 ge;
    logic [DIM_W-1:0]     n_rem;
    logic [FRAME_W-1:0]   n_quo;
    logic [2*DIM_W-1:0]   prod_dh;
    logic [2*DIM_W-1:0]   prod_frame;
    logic [FRAME_W-1:0]   op_dividend;
    logic [DIM_W-1:0]     op_divisor;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;

    always_comb begin
        unique case (t_reg_idx'(paddr[3:2]))
            REG_SRC_WIDTH:     prdata = {23'b0, r_sw};
            REG_SRC_HEIGHT:    prdata = {23'b0, r_sh};
            REG_DST_WIDTH:     prdata = {23'b0, r_dw};
            REG_CHANNEL_COUNT: prdata = {29'b0, r_chan};
        endcase
    end

    // one restoring step per cycle
    always_comb begin
        t     = {r_rem, r_quo[FRAME_W-1]};
        ge    = t >= {1'b0, r_divisor};
        n_rem = ge ? DIM_W'(t - {1'b0, r_divisor}) : t[DIM_W-1:0];
        n_quo = {r_quo[FRAME_W-2:0], ge};
    end

    assign prod_dh    = (2*DIM_W)'(r_dw) * (2*DIM_W)'(r_sh);
    assign prod_frame = (2*DIM_W)'(r_sw) * (2*DIM_W)'(r_sh);

    always_comb begin
        unique case (r_state)
            ST_DH: begin
                op_dividend = prod_dh[FRAME_W-1:0];
                op_divisor  = r_sw;
            end
            ST_WDIV: begin
                op_dividend = FRAME_W'(r_sw);
                op_divisor  = r_dw;
            end
            ST_WINIT: begin
                op_dividend = FRAME_W'(r_sw - DIM_W'(1));
                op_divisor  = r_dw;
            end
            ST_HDIV: begin
                op_dividend = FRAME_W'(r_sh);
                op_divisor  = r_geom.dest_height;
            end
            ST_HINIT: begin
                op_dividend = FRAME_W'(r_sh - DIM_W'(1));
                op_divisor  = r_geom.dest_height;
            end
            default: begin
                op_dividend = '0;
                op_divisor  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state              <= ST_IDLE;
            r_load               <= 1'b0;
            r_done               <= 1'b0;
            r_cnt                <= '0;
            r_sw                 <= DIM_W'(1);
            r_sh                 <= DIM_W'(1);
            r_dw                 <= DIM_W'(1);
            r_chan               <= 3'd3;
            r_geom.src_width     <= DIM_W'(1);
            r_geom.dst_width     <= DIM_W'(1);
            r_geom.dest_height   <= DIM_W'(1);
            r_geom.frame         <= FRAME_W'(1);
            r_geom.wdiv          <= DIM_W'(1);
            r_geom.wmod          <= '0;
            r_geom.winit_q       <= '0;
            r_geom.winit_r       <= '0;
            r_geom.hdiv          <= DIM_W'(1);
            r_geom.hmod          <= '0;
            r_geom.hinit_q       <= '0;
            r_geom.hinit_r       <= '0;
            r_geom.alpha_en      <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (wr) begin
                unique case (t_reg_idx'(paddr[3:2]))
                    REG_SRC_WIDTH:
                        r_sw <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_WIDTH));
                    REG_SRC_HEIGHT:
                        r_sh <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_HEIGHT));
                    REG_DST_WIDTH:
                        r_dw <= clamp_dim(pwdata[DIM_W-1:0], DIM_W'(MAX_WIDTH));
                    REG_CHANNEL_COUNT:
                        r_chan <= pwdata[2:0];
                endcase
                r_state <= ST_DH;
                r_load  <= 1'b1;
            end else if (r_state != ST_IDLE) begin
                if (r_load) begin
                    r_load    <= 1'b0;
                    r_cnt     <= LAST_STEP;
                    r_rem     <= '0;
                    r_quo     <= op_dividend;
                    r_divisor <= op_divisor;
                    if (r_state == ST_DH) begin
                        r_geom.frame     <= prod_frame[FRAME_W-1:0];
                        r_geom.src_width <= r_sw;
                        r_geom.dst_width <= r_dw;
                        r_geom.alpha_en  <= (r_chan == 3'd4);
                    end
                end else begin
                    r_rem <= n_rem;
                    r_quo <= n_quo;
                    if (r_cnt == '0) begin
                        r_load <= 1'b1;
                        unique case (r_state)
                            ST_DH: begin
                                // clamp to the store height
                                r_geom.dest_height <= (n_quo > FRAME_W'(MAX_HEIGHT)) ?
                                    DIM_W'(MAX_HEIGHT) : n_quo[DIM_W-1:0];
                                r_state <= ST_WDIV;
                            end
                            ST_WDIV: begin
                                r_geom.wdiv <= n_quo[DIM_W-1:0];
                                r_geom.wmod <= n_rem[CRD_W-1:0];
                                r_state     <= ST_WINIT;
                            end
                            ST_WINIT: begin
                                r_geom.winit_q <= n_quo[CRD_W-1:0];
                                r_geom.winit_r <= n_rem[CRD_W-1:0];
                                r_state        <= ST_HDIV;
                            end
                            ST_HDIV: begin
                                r_geom.hdiv <= n_quo[DIM_W-1:0];
                                r_geom.hmod <= n_rem[CRD_W-1:0];
                                r_state     <= ST_HINIT;
                            end
                            ST_HINIT: begin
                                r_geom.hinit_q <= n_quo[CRD_W-1:0];
                                r_geom.hinit_r <= n_rem[CRD_W-1:0];
                                r_state        <= ST_IDLE;
                                r_load         <= 1'b0;
                                r_done         <= 1'b1;
                            end
                            default: r_state <= ST_IDLE;
                        endcase
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
            end
        end
    end

    assign o_geom         = r_geom;
    assign o_stat.busy    = (r_state != ST_IDLE) | r_done;
    assign o_stat.restart = r_done;

endmodule

@@ rtl/nnis_front.sv @@
// input side: accepts beats, keeps load and emit cursors, maps emits to store addresses
module nnis_front import nnis_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_operation,
    input  logic [PIX_W-1:0] i_pixel,
    input  t_geom            i_geom,
    input  t_setup_stat      i_stat,
    input  logic             i_q_full,
    output logic             o_push,
    output t_qent            o_push_data
);

    logic [ADDR_W-1:0] r_lp;
    logic [CRD_W-1:0]  r_col;
    logic [CRD_W-1:0]  r_line;
    logic [CRD_W-1:0]  r_sc_q;
    logic [CRD_W-1:0]  r_sc_r;
    logic [CRD_W-1:0]  r_sr_q;
    logic [CRD_W-1:0]  r_sr_r;

    logic               accept;
    logic               is_emit;
    logic               has_rows;
    logic               col_last;
    logic               line_last;
    logic [DIM_W-1:0]   col_sum;
    logic               col_wrap;
    logic [CRD_W-1:0]   n_sc_q;
    logic [CRD_W-1:0]   n_sc_r;
    logic [DIM_W-1:0]   row_sum;
    logic               row_wrap;
    logic [CRD_W-1:0]   n_sr_q;
    logic [CRD_W-1:0]   n_sr_r;
    logic [FRAME_W-1:0] lp_inc;
    logic [FRAME_W-1:0] row_base;
    logic [ADDR_W-1:0]  emit_addr;

    assign o_stall  = i_q_full | i_stat.busy;
    assign accept   = i_valid & ~o_stall;
    assign is_emit  = (t_op'(i_operation) == OP_EMIT);
    assign has_rows = (i_geom.dest_height != '0);
    assign o_push   = accept & (~is_emit | has_rows);

    assign col_last  = ({1'b0, r_col} + DIM_W'(1)) == i_geom.dst_width;
    assign line_last = ({1'b0, r_line} + DIM_W'(1)) == i_geom.dest_height;

    // source column and row follow by quotient and remainder steps
    always_comb begin
        col_sum  = {1'b0, r_sc_r} + {1'b0, i_geom.wmod};
        col_wrap = col_sum >= i_geom.dst_width;
        n_sc_r   = col_wrap ? CRD_W'(col_sum - i_geom.dst_width) : col_sum[CRD_W-1:0];
        n_sc_q   = CRD_W'({1'b0, r_sc_q} + i_geom.wdiv + DIM_W'(col_wrap));
        row_sum  = {1'b0, r_sr_r} + {1'b0, i_geom.hmod};
        row_wrap = row_sum >= i_geom.dest_height;
        n_sr_r   = row_wrap ? CRD_W'(row_sum - i_geom.dest_height) : row_sum[CRD_W-1:0];
        n_sr_q   = CRD_W'({1'b0, r_sr_q} + i_geom.hdiv + DIM_W'(row_wrap));
    end

    assign lp_inc    = {1'b0, r_lp} + FRAME_W'(1);
    assign row_base  = FRAME_W'(r_sr_q) * FRAME_W'(i_geom.src_width);
    assign emit_addr = row_base[ADDR_W-1:0] + ADDR_W'(r_sc_q);

    always_comb begin
        o_push_data.op   = is_emit ? OP_EMIT : OP_LOAD;
        o_push_data.addr = is_emit ? emit_addr : r_lp;
        o_push_data.data = i_pixel;
        o_push_data.col  = r_col;
        o_push_data.row  = r_line;
        o_push_data.last = col_last & line_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lp   <= '0;
            r_col  <= '0;
            r_line <= '0;
            r_sc_q <= '0;
            r_sc_r <= '0;
            r_sr_q <= '0;
            r_sr_r <= '0;
        end else if (i_stat.restart) begin
            r_lp   <= '0;
            r_col  <= '0;
            r_line <= '0;
            r_sc_q <= i_geom.winit_q;
            r_sc_r <= i_geom.winit_r;
            r_sr_q <= i_geom.hinit_q;
            r_sr_r <= i_geom.hinit_r;
        end else if (accept) begin
            if (!is_emit) begin
                r_lp <= (lp_inc >= i_geom.frame) ? '0 : lp_inc[ADDR_W-1:0];
            end else if (has_rows) begin
                if (col_last) begin
                    r_col  <= '0;
                    r_sc_q <= i_geom.winit_q;
                    r_sc_r <= i_geom.winit_r;
                    if (line_last) begin
                        r_line <= '0;
                        r_sr_q <= i_geom.hinit_q;
                        r_sr_r <= i_geom.hinit_r;
                    end else begin
                        r_line <= r_line + CRD_W'(1);
                        r_sr_q <= n_sr_q;
                        r_sr_r <= n_sr_r;
                    end
                end else begin
                    r_col  <= r_col + CRD_W'(1);
                    r_sc_q <= n_sc_q;
                    r_sc_r <= n_sc_r;
                end
            end
        end
    end

endmodule

@@ rtl/nnis_fifo.sv @@
// short command queue between the front and back parts
module nnis_fifo import nnis_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_qent i_data,
    input  logic  i_pop,
    output t_qent o_data,
    output logic  o_valid,
    output logic  o_full
);

    t_qent             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + (QPTR_W+1)'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

@@ rtl/nnis_back.sv @@
// back part: frame store writes and reads, read stage and output register
module nnis_back import nnis_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_qent             i_q_data,
    output logic              o_pop,
    input  logic              i_alpha_en,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [PIX_W-1:0]  o_pixel,
    output logic [CRD_W-1:0]  o_col,
    output logic [CRD_W-1:0]  o_row,
    output logic              o_last
);

    logic [PIX_W-1:0] r_store [STORE_DEPTH];
    logic [PIX_W-1:0] r_rd;
    logic             r_s1_v;
    logic [CRD_W-1:0] r_s1_col;
    logic [CRD_W-1:0] r_s1_row;
    logic             r_s1_last;
    logic             r_o_v;
    logic [PIX_W-1:0] r_o_pixel;
    logic [CRD_W-1:0] r_o_col;
    logic [CRD_W-1:0] r_o_row;
    logic             r_o_last;

    logic s1_move;
    logic s1_free;
    logic pop_load;
    logic pop_emit;

    assign s1_move  = r_s1_v & (~r_o_v | ~i_stall);
    assign s1_free  = ~r_s1_v | s1_move;
    // loads never wait on the output side
    assign o_pop    = i_q_valid & ((i_q_data.op == OP_LOAD) | s1_free);
    assign pop_load = o_pop & (i_q_data.op == OP_LOAD);
    assign pop_emit = o_pop & (i_q_data.op == OP_EMIT);

    always_ff @(posedge i_clk) begin
        if (pop_load) begin
            r_store[i_q_data.addr] <= i_q_data.data;
        end
        if (pop_emit) begin
            r_rd <= r_store[i_q_data.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_emit) begin
            r_s1_col  <= i_q_data.col;
            r_s1_row  <= i_q_data.row;
            r_s1_last <= i_q_data.last;
        end
        if (s1_move) begin
            r_o_pixel <= i_alpha_en ? r_rd : {8'b0, r_rd[23:0]};
            r_o_col   <= r_s1_col;
            r_o_row   <= r_s1_row;
            r_o_last  <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_o_v  <= 1'b0;
        end else begin
            priority if (pop_emit) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end else begin
                r_s1_v <= r_s1_v;
            end
            priority if (s1_move) begin
                r_o_v <= 1'b1;
            end else if (!i_stall) begin
                r_o_v <= 1'b0;
            end else begin
                r_o_v <= r_o_v;
            end
        end
    end

    assign o_valid = r_o_v;
    assign o_pixel = r_o_pixel;
    assign o_col   = r_o_col;
    assign o_row   = r_o_row;
    assign o_last  = r_o_last;

endmodule

@@ rtl/nearest_neighbour_image_scaler_unit.sv @@
// top level of the nearest-neighbor image scaler
//
//  channel  direction  handshake                     payload
//  in       input      i_in_valid / o_in_stall       i_operation, i_pixel_in
//  out      output     o_out_valid / i_out_stall     o_pixel_out, o_dest_col, o_dest_row,
//                                                    o_final_pixel
//  cfg      input      psel, penable, pwrite, pready paddr, pwdata, prdata
//
//  one beat per cycle in while o_in_stall is low; an emit result passes through the queue,
//  the store read stage and the output register
//  after a register write the input stalls while the setup divider runs five 17-bit
//  divisions and the front loads its cursors
//  synchronous active-low reset; the frame store is not cleared
//  an output stall fills the output register, the read stage and the 4-entry queue,
//  then stalls the input
module nearest_neighbour_image_scaler_unit import nnis_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [REG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_operation,
    input  logic [PIX_W-1:0]      i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [PIX_W-1:0]      o_pixel_out,
    output logic [CRD_W-1:0]      o_dest_col,
    output logic [CRD_W-1:0]      o_dest_row,
    output logic                  o_final_pixel
);

    t_geom       geom;
    t_setup_stat stat;
    logic        q_push;
    t_qent       q_push_data;
    logic        q_full;
    logic        q_pop;
    t_qent       q_data;
    logic        q_valid;

    nnis_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_geom  (geom),
        .o_stat  (stat)
    );

    nnis_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_operation (i_operation),
        .i_pixel     (i_pixel_in),
        .i_geom      (geom),
        .i_stat      (stat),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_push_data (q_push_data)
    );

    nnis_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_push_data),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    nnis_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_data   (q_data),
        .o_pop      (q_pop),
        .i_alpha_en (geom.alpha_en),
        .o_valid    (o_out_valid),
        .i_stall    (i_out_stall),
        .o_pixel    (o_pixel_out),
        .o_col      (o_dest_col),
        .o_row      (o_dest_row),
        .o_last     (o_final_pixel)
    );

    // the front never pushes into a full queue
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    // the back only pops an occupied queue
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue pop while empty");

    // a register write starts the geometry update and holds off input beats
    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready) |=> (stat.busy && o_in_stall))
        else $error("register write did not start geometry update");

endmodule

@@ sim/nearest_neighbour_image_scaler_unit_test.sv @@
// self-checking testbench of the nearest-neighbor image scaler: directed frames, clamps, random frames
module nearest_neighbour_image_scaler_unit_test;
    import nnis_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_TAIL  = 6;

    typedef struct {
        logic [PIX_W-1:0] pix;
        logic [CRD_W-1:0] col;
        logic [CRD_W-1:0] row;
        logic             last;
    } t_dest_pixel;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [REG_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation = 1'b0;
    logic [PIX_W-1:0]      i_pixel_in = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [PIX_W-1:0]      o_pixel_out;
    logic [CRD_W-1:0]      o_dest_col;
    logic [CRD_W-1:0]      o_dest_row;
    logic                  o_final_pixel;

    // scaler state as seen by the predictor
    int unsigned  scaler_src_w, scaler_src_h, scaler_dst_w, scaler_dst_h;
    bit           scaler_alpha;
    int unsigned  load_cursor, out_col, out_line;
    logic [31:0]  source_copy [STORE_DEPTH];
    bit           source_written [STORE_DEPTH];

    t_dest_pixel  pending_pixels[$];
    int           error_count = 0;
    int           cycle_count = 0;
    int unsigned  counted_beats = 0;
    bit           no_idle = 1'b0;

    nearest_neighbour_image_scaler_unit dut (.*);

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("nearest_neighbour_image_scaler_unit: mismatch");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= !no_idle && ($urandom_range(99) < 32);
    end

    function automatic int unsigned clamp_dim(logic [31:0] v, int unsigned maxv);
        int unsigned d;
        d = {23'b0, v[8:0]};
        if (d == 0) return 1;
        if (d > maxv) return maxv;
        return d;
    endfunction

    function automatic void restart_frame();
        scaler_dst_h = (scaler_dst_w * scaler_src_h) / scaler_src_w;
        if (scaler_dst_h > MAX_HEIGHT) scaler_dst_h = MAX_HEIGHT;
        load_cursor = 0;
        out_col = 0;
        out_line = 0;
    endfunction

    function automatic void apply_register(t_reg_idx idx, logic [31:0] v);
        case (idx)
            REG_SRC_WIDTH:     scaler_src_w = clamp_dim(v, MAX_WIDTH);
            REG_SRC_HEIGHT:    scaler_src_h = clamp_dim(v, MAX_HEIGHT);
            REG_DST_WIDTH:     scaler_dst_w = clamp_dim(v, MAX_WIDTH);
            REG_CHANNEL_COUNT: scaler_alpha = (v[2:0] == 3'd4);
            default: ;
        endcase
        restart_frame();
    endfunction

    // store index the next emit reads, -1 when the destination has no rows
    function automatic int emit_source_index();
        int unsigned c, l, sc, sr;
        if (scaler_dst_h == 0) return -1;
        c = (out_col >= scaler_dst_w) ? 0 : out_col;
        l = (out_line >= scaler_dst_h) ? 0 : out_line;
        sc = ((c + 1) * scaler_src_w - 1) / scaler_dst_w;
        sr = ((l + 1) * scaler_src_h - 1) / scaler_dst_h;
        return int'(sr * scaler_src_w + sc);
    endfunction

    function automatic void advance_scaler(t_op op, logic [31:0] pix);
        int          src;
        int unsigned frame;
        t_dest_pixel r;
        frame = scaler_src_w * scaler_src_h;
        if (op == OP_LOAD) begin
            if (load_cursor >= frame) load_cursor = 0;
            source_copy[load_cursor] = pix;
            source_written[load_cursor] = 1'b1;
            load_cursor++;
            if (load_cursor >= frame) load_cursor = 0;
            counted_beats++;
            return;
        end
        src = emit_source_index();
        if (src < 0) return;
        counted_beats++;
        if (out_col >= scaler_dst_w) out_col = 0;
        if (out_line >= scaler_dst_h) out_line = 0;
        r.pix = source_copy[src];
        if (!scaler_alpha) r.pix[31:24] = 8'h00;
        r.col = out_col[CRD_W-1:0];
        r.row = out_line[CRD_W-1:0];
        r.last = (out_col + 1 == scaler_dst_w) && (out_line + 1 == scaler_dst_h);
        pending_pixels.push_back(r);
        out_col++;
        if (out_col >= scaler_dst_w) begin
            out_col = 0;
            out_line++;
            if (out_line >= scaler_dst_h) out_line = 0;
        end
    endfunction

    always @(posedge i_clk) begin : check_pixels
        t_dest_pixel want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pixels.size() == 0) begin
                error_count++;
                $display("%0t: result beat expected none, actual pixel %h col %0d row %0d",
                         $time, o_pixel_out, o_dest_col, o_dest_row);
            end else begin
                want = pending_pixels.pop_front();
                if (o_pixel_out !== want.pix) begin
                    error_count++;
                    $display("%0t: pixel_out expected %h actual %h", $time, want.pix,
                             o_pixel_out);
                end
                if (o_dest_col !== want.col) begin
                    error_count++;
                    $display("%0t: dest_col expected %0d actual %0d", $time, want.col,
                             o_dest_col);
                end
                if (o_dest_row !== want.row) begin
                    error_count++;
                    $display("%0t: dest_row expected %0d actual %0d", $time, want.row,
                             o_dest_row);
                end
                if (o_final_pixel !== want.last) begin
                    error_count++;
                    $display("%0t: final_pixel expected %b actual %b", $time, want.last,
                             o_final_pixel);
                end
            end
        end
    end

    task automatic send_beat(t_op op, logic [31:0] pix);
        while (!no_idle && $urandom_range(99) < 32) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_pixel_in  <= pix;
        do @(posedge i_clk); while (o_in_stall);
        advance_scaler(op, pix);
    endtask

    // emit when the mapped source pixel is already loaded, else load one more pixel
    task automatic emit_or_load();
        int src;
        src = emit_source_index();
        if (src >= 0 && !source_written[src]) send_beat(OP_LOAD, $urandom());
        else send_beat(OP_EMIT, $urandom());
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        // a trailing load may still be in the pipe
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    task automatic write_register(t_reg_idx idx, logic [31:0] v);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        apply_register(idx, v);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_geometry(logic [31:0] sw, logic [31:0] sh, logic [31:0] dw,
                                  logic [31:0] ch);
        drain_results();
        write_register(REG_SRC_WIDTH, sw);
        write_register(REG_SRC_HEIGHT, sh);
        write_register(REG_DST_WIDTH, dw);
        write_register(REG_CHANNEL_COUNT, ch);
    endtask

    // 1x1 frame after reset: alpha dropped, emit wraps, load wraps
    task automatic test_reset_geometry();
        send_beat(OP_LOAD, 32'hFFFF_FFFF);
        send_beat(OP_EMIT, 32'h0000_0000);
        send_beat(OP_EMIT, 32'hFFFF_FFFF);
        send_beat(OP_LOAD, 32'h0000_0000);
        send_beat(OP_EMIT, 32'h0000_0000);
    endtask

    // 3x2 source upscaled to 5x3 with alpha kept, upper pwdata bits set
    task automatic test_small_frame();
        logic [31:0] pixels [6];
        pixels = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA,
                   32'h8000_0001, 32'h7FFF_FFFE};
        write_geometry(32'hFFFF_FE03, 32'h0000_0002, 32'h8000_0005, 32'hFFFF_FFFC);
        foreach (pixels[k]) send_beat(OP_LOAD, pixels[k]);
        repeat (16) send_beat(OP_EMIT, $urandom());
    endtask

    // destination height rounds to zero: emits are dropped
    task automatic test_zero_height();
        write_geometry(32'd5, 32'd1, 32'd2, 32'd3);
        send_beat(OP_LOAD, $urandom());
        send_beat(OP_EMIT, $urandom());
        send_beat(OP_LOAD, $urandom());
        send_beat(OP_EMIT, $urandom());
        drain_results();
    endtask

    // zero and oversized registers clamp, height clamps, odd channel count drops alpha
    task automatic test_register_clamp();
        write_geometry(32'd0, 32'd300, 32'd511, 32'd7);
        repeat (260) emit_or_load();
    endtask

    // full-width row with no idling on either side
    task automatic test_widest_row();
        write_geometry(32'd256, 32'd1, 32'd256, 32'd4);
        no_idle = 1'b1;
        repeat (256) send_beat(OP_LOAD, $urandom());
        repeat (257) send_beat(OP_EMIT, $urandom());
        no_idle = 1'b0;
    endtask

    function automatic logic [31:0] encode_dim(int unsigned d);
        logic [31:0] v;
        v = d;
        if (d == 1 && $urandom_range(1) == 1) v = 0;
        if (d == 256 && $urandom_range(1) == 1) v = $urandom_range(511, 256);
        if ($urandom_range(3) == 0) v[31:9] = 23'($urandom());
        return v;
    endfunction

    task automatic test_random_frames();
        int unsigned start, phase, w, h, d, frame, n_load, n_emit, full;
        logic [31:0] ch;
        start = counted_beats;
        phase = 0;
        while (counted_beats - start < 150) begin
            drain_results();
            no_idle = (phase == 2 || phase == 3 || phase == 4);
            if ($urandom_range(3) != 0) begin
                w = $urandom_range(12, 1);
                h = $urandom_range(8, 1);
                d = $urandom_range(16, 1);
                case ($urandom_range(7))
                    0: begin w = 256; h = 1; end
                    1: d = 256;
                    2: begin w = 1; h = 256; end
                    3: d = 1;
                    default: ;
                endcase
                if (w * h > 256) h = (256 / w > 0) ? 256 / w : 1;
                ch = ($urandom_range(1) == 1) ? 32'd4 : $urandom_range(7);
                if ($urandom_range(3) == 0) ch[31:3] = 29'($urandom());
                write_register(REG_SRC_WIDTH, encode_dim(w));
                write_register(REG_SRC_HEIGHT, encode_dim(h));
                write_register(REG_DST_WIDTH, encode_dim(d));
                write_register(REG_CHANNEL_COUNT, ch);
            end else if ($urandom_range(1) == 1) begin
                write_register(REG_CHANNEL_COUNT, $urandom());
            end else begin
                write_register(REG_DST_WIDTH, encode_dim($urandom_range(16, 1)));
            end
            frame = scaler_src_w * scaler_src_h;
            if ($urandom_range(9) != 0) begin
                n_load = (frame > 300) ? 300 : frame;
                if ($urandom_range(3) == 0) n_load += $urandom_range(frame, 1);
                repeat (n_load) send_beat(OP_LOAD, $urandom());
                full = scaler_dst_w * scaler_dst_h + scaler_dst_w;
                if (full > 160) full = 160;
                n_emit = (scaler_dst_h == 0) ? $urandom_range(3, 1) : $urandom_range(full, 1);
                repeat (n_emit) begin
                    if ($urandom_range(199) == 0) drain_results();
                    emit_or_load();
                end
            end else begin
                repeat ($urandom_range(40, 5)) begin
                    if ($urandom_range(1) == 1) emit_or_load();
                    else send_beat(OP_LOAD, $urandom());
                end
            end
            phase++;
        end
        no_idle = 1'b0;
    endtask

    initial begin
        scaler_src_w = 1;
        scaler_src_h = 1;
        scaler_dst_w = 1;
        scaler_alpha = 1'b0;
        restart_frame();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_geometry();
        test_small_frame();
        test_zero_height();
        test_register_clamp();
        test_widest_row();
        test_random_frames();
        drain_results();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("nearest_neighbour_image_scaler_unit: match");
        end else begin
            $display("nearest_neighbour_image_scaler_unit: mismatch");
        end
        $finish;
    end

endmodule
